### rtl/cat_pkg.sv
// Shared types, character constants and helper functions for the atom classifier.
package cat_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned PosW  = 4;
  localparam int unsigned ClassW = 3;

  localparam logic [PosW-1:0] PosSat    = 4'd11;
  localparam logic [PosW-1:0] HexMinLen = 4'd3;
  localparam logic [PosW-1:0] HexMaxLen = 4'd10;
  localparam logic [PosW-1:0] TrueLen   = 4'd4;
  localparam logic [PosW-1:0] FalseLen  = 4'd5;

  localparam logic [CharW-1:0] ChDot   = 8'h2E;
  localparam logic [CharW-1:0] ChAt    = 8'h40;
  localparam logic [CharW-1:0] ChQuote = 8'h22;
  localparam logic [CharW-1:0] ChApos  = 8'h27;
  localparam logic [CharW-1:0] ChTick  = 8'h60;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChLowX  = 8'h78;

  typedef enum logic [ClassW-1:0] {
    ClsInt     = 3'd0,
    ClsDecimal = 3'd1,
    ClsHex     = 3'd2,
    ClsChar    = 3'd3,
    ClsString  = 3'd4,
    ClsBool    = 3'd5,
    ClsSymbol  = 3'd6,
    ClsNone    = 3'd7
  } atom_class_e;

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c >= ChZero) && (c <= ChNine);
  endfunction

  function automatic logic is_graph(input logic [CharW-1:0] c);
    return (c >= 8'h21) && (c <= 8'h7E);
  endfunction

  function automatic logic is_hex(input logic [CharW-1:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // Expected letter of "true" at a position below four.
  function automatic logic [CharW-1:0] true_char(input logic [1:0] pos);
    logic [CharW-1:0] ch;
    unique case (pos)
      2'd0: ch = 8'h74;
      2'd1: ch = 8'h72;
      2'd2: ch = 8'h75;
      default: ch = 8'h65;
    endcase
    return ch;
  endfunction

  // Expected letter of "false" at a position below five.
  function automatic logic [CharW-1:0] false_char(input logic [PosW-1:0] pos);
    logic [CharW-1:0] ch;
    unique case (pos)
      4'd1: ch = 8'h61;
      4'd2: ch = 8'h6C;
      4'd3: ch = 8'h73;
      4'd4: ch = 8'h65;
      default: ch = 8'h66;
    endcase
    return ch;
  endfunction

endpackage

### rtl/cat_scan.sv
// Per-atom flag registers and the class decision for the atom classifier.
module cat_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic [cat_pkg::CharW-1:0] char_i,
  input  logic                     last_i,
  output cat_pkg::atom_class_e     class_o
);

  logic [cat_pkg::PosW-1:0] pos_q, pos_d;
  logic all_digit_q, all_digit_d;
  logic dec_ok_q, dec_ok_d;
  logic dot_seen_q, dot_seen_d;
  logic hex_ok_q, hex_ok_d;
  logic at_first_q, at_first_d;
  logic quote_first_q, quote_first_d;
  logic graph_second_q, graph_second_d;
  logic true_ok_q, true_ok_d;
  logic false_ok_q, false_ok_d;
  logic sym_ok_q, sym_ok_d;
  logic digit;

  always_comb begin
    digit = cat_pkg::is_digit(char_i);
    all_digit_d = all_digit_q & digit;

    dec_ok_d   = dec_ok_q;
    dot_seen_d = dot_seen_q;
    if (char_i == cat_pkg::ChDot) begin
      if ((pos_q == '0) || dot_seen_q || last_i) begin
        dec_ok_d = 1'b0;
      end
      dot_seen_d = 1'b1;
    end else if (!digit) begin
      dec_ok_d = 1'b0;
    end

    hex_ok_d = hex_ok_q;
    if (pos_q == 4'd0) begin
      if (char_i != cat_pkg::ChZero) hex_ok_d = 1'b0;
    end else if (pos_q == 4'd1) begin
      if (char_i != cat_pkg::ChLowX) hex_ok_d = 1'b0;
    end else if (!cat_pkg::is_hex(char_i)) begin
      hex_ok_d = 1'b0;
    end

    at_first_d     = at_first_q | ((pos_q == 4'd0) && (char_i == cat_pkg::ChAt));
    quote_first_d  = quote_first_q | ((pos_q == 4'd0) && (char_i == cat_pkg::ChQuote));
    graph_second_d = graph_second_q | ((pos_q == 4'd1) && cat_pkg::is_graph(char_i));

    true_ok_d  = true_ok_q & (pos_q < cat_pkg::TrueLen) &
                 (char_i == cat_pkg::true_char(pos_q[1:0]));
    false_ok_d = false_ok_q & (pos_q < cat_pkg::FalseLen) &
                 (char_i == cat_pkg::false_char(pos_q));

    sym_ok_d = sym_ok_q & (char_i != cat_pkg::ChDot) &
               !((pos_q != '0) && ((char_i == cat_pkg::ChQuote) || (char_i == cat_pkg::ChAt) ||
                                   (char_i == cat_pkg::ChApos) || (char_i == cat_pkg::ChTick)));

    pos_d = (pos_q < cat_pkg::PosSat) ? pos_q + 4'd1 : cat_pkg::PosSat;
  end

  // The class is decided from the flags as they stand after this character.
  always_comb begin
    priority if (all_digit_d) begin
      class_o = cat_pkg::ClsInt;
    end else if (dec_ok_d) begin
      class_o = cat_pkg::ClsDecimal;
    end else if (hex_ok_d && (pos_d >= cat_pkg::HexMinLen) && (pos_d <= cat_pkg::HexMaxLen)) begin
      class_o = cat_pkg::ClsHex;
    end else if (at_first_d && graph_second_d) begin
      class_o = cat_pkg::ClsChar;
    end else if (quote_first_d && (char_i == cat_pkg::ChQuote)) begin
      class_o = cat_pkg::ClsString;
    end else if ((true_ok_d && (pos_d == cat_pkg::TrueLen)) ||
                 (false_ok_d && (pos_d == cat_pkg::FalseLen))) begin
      class_o = cat_pkg::ClsBool;
    end else if (sym_ok_d) begin
      class_o = cat_pkg::ClsSymbol;
    end else begin
      class_o = cat_pkg::ClsNone;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q          <= '0;
      all_digit_q    <= 1'b1;
      dec_ok_q       <= 1'b1;
      dot_seen_q     <= 1'b0;
      hex_ok_q       <= 1'b1;
      at_first_q     <= 1'b0;
      quote_first_q  <= 1'b0;
      graph_second_q <= 1'b0;
      true_ok_q      <= 1'b1;
      false_ok_q     <= 1'b1;
      sym_ok_q       <= 1'b1;
    end else if (step_i && last_i) begin
      pos_q          <= '0;
      all_digit_q    <= 1'b1;
      dec_ok_q       <= 1'b1;
      dot_seen_q     <= 1'b0;
      hex_ok_q       <= 1'b1;
      at_first_q     <= 1'b0;
      quote_first_q  <= 1'b0;
      graph_second_q <= 1'b0;
      true_ok_q      <= 1'b1;
      false_ok_q     <= 1'b1;
      sym_ok_q       <= 1'b1;
    end else if (step_i) begin
      pos_q          <= pos_d;
      all_digit_q    <= all_digit_d;
      dec_ok_q       <= dec_ok_d;
      dot_seen_q     <= dot_seen_d;
      hex_ok_q       <= hex_ok_d;
      at_first_q     <= at_first_d;
      quote_first_q  <= quote_first_d;
      graph_second_q <= graph_second_d;
      true_ok_q      <= true_ok_d;
      false_ok_q     <= false_ok_d;
      sym_ok_q       <= sym_ok_d;
    end
  end

  // The position counter never passes its saturation value.
  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= cat_pkg::PosSat)
    else $error("position counter above saturation");

  // A finished atom leaves the scanner at its first position.
  a_pos_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && last_i) |=> (pos_q == '0))
    else $error("position not cleared after last character");

  // An all-digit prefix is always still a valid decimal prefix.
  a_digit_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    all_digit_q |-> dec_ok_q)
    else $error("digit flag set while decimal flag cleared");

endmodule

### rtl/classify_atom_token.sv
// Top level of the atom classifier: input register, flag scanner and result register.
//
// Usage: the characters of one non-empty atom arrive on the input channel, one
// per transaction, with is_last_i high on the final character. Each input
// transaction is captured in an input register. From there the scanner updates
// its flags; a character that is not the last produces nothing, while the last
// one produces exactly one output transaction carrying the atom's class
// (integer, decimal, hex, character, string, boolean, symbol or unclassified,
// tested in that priority) and clears the flags for the next atom.
// A last character moves from the input register into the result register,
// whose valid bit drives out_valid_o, once that register is free; the
// receiver takes the class from there while out_stall_i is low.
// Throughput: one character per cycle unless stalled, with no gaps between atoms;
// the flag update is a single pass of short logic between the two registers.
// When the receiver stalls, the result register holds its transaction; the
// input register may still drain characters that are not last, and only a last
// character waiting behind a held result makes in_stall_o rise.
// Reset clears both valid bits and returns every flag to its start value.
module classify_atom_token (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [cat_pkg::CharW-1:0] char_code_i,
  input  logic                      is_last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [cat_pkg::ClassW-1:0] atom_class_o
);

  logic                      in_valid_q, in_valid_d;
  logic [cat_pkg::CharW-1:0] in_char_q;
  logic                      in_last_q;
  logic                      out_valid_q, out_valid_d;
  cat_pkg::atom_class_e      out_class_q;
  cat_pkg::atom_class_e      scan_class;
  logic                      out_free;
  logic                      advance;
  logic                      accept;

  // A character that is not last never needs the result register, so it can
  // always move on; a last one waits until the result register frees up.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (!in_last_q || out_free);
  assign in_stall_o = in_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  cat_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .char_i  (in_char_q),
    .last_i  (in_last_q),
    .class_o (scan_class)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_char_q <= char_code_i;
      in_last_q <= is_last_i;
    end
    if (advance && in_last_q) begin
      out_class_q <= scan_class;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign atom_class_o = out_class_q;

  // A result appears only after a last character left the input register.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(advance && in_last_q))
    else $error("result appeared without a last character");

  // Input stalls only for a last character blocked by a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_last_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  // A held result is never overwritten by a new class.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_class_q)))
    else $error("held result was overwritten");

endmodule
